// ===== rtl/ups_pkg.sv =====
// shared types and constants of the ultrasonic presence throttle unit
package ups_pkg;

    // round size default and fixed arithmetic constants
    localparam int C_SAMPLES_PER_ROUND = 8;
    localparam int C_CM_DIVISOR        = 58;
    localparam int C_CHANGE_CM         = 20;
    localparam int C_THROTTLE_STEP_MS  = 125;
    localparam int C_THROTTLE_EVERY    = 10;
    localparam int C_COUNT_MAX         = 65535;

    // field widths
    localparam int C_PULSE_W    = 16;
    localparam int C_CM_MAX     = 65535 / C_CM_DIVISOR;
    localparam int C_CM_W       = $clog2(C_CM_MAX + 1);
    localparam int C_MEAN_W     = 15;
    localparam int C_COUNT_W    = 16;
    localparam int C_DELAY_W    = 17;
    localparam int C_WAIT_W     = 18;
    localparam int C_MS_W       = 16;
    localparam int C_MOD_W      = $clog2(C_THROTTLE_EVERY);

    // shared reciprocal divider sizing, covers every round size up to 32 samples
    localparam int C_DIV_W      = 19;
    localparam int C_RCP_W      = 20;
    localparam int C_SHIFT_W    = 5;

    // pulse / 58 as (pulse * 72316) >> 22, exact for every 16 bit pulse
    localparam int C_CM_RECIP   = 72316;
    localparam int C_CM_SHIFT   = 22;

    // configuration port
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 16;
    localparam logic [C_MS_W-1:0] C_BASE_DELAY_RESET = 16'd1250;
    localparam logic [C_MS_W-1:0] C_MAX_DELAY_RESET  = 16'd4000;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_THROTTLE_ENABLE = 2'd0,
        CFG_BASE_DELAY_MS   = 2'd1,
        CFG_MAX_DELAY_MS    = 2'd2
    } t_cfg_reg;

    // input item
    typedef struct packed {
        logic                 side;
        logic [C_PULSE_W-1:0] pulse_us;
    } t_item;

    // result item
    typedef struct packed {
        logic                 out_side;
        logic [C_MEAN_W-1:0]  mean_cm_q4;
        logic                 changed;
        logic                 report;
        logic [C_COUNT_W-1:0] inactive_rounds;
        logic [C_DELAY_W-1:0] throttle_ms;
        logic [C_WAIT_W-1:0]  wait_ms;
    } t_result;

    // request to the shared divider: dividend, reciprocal and shift
    typedef struct packed {
        logic                 start;
        logic [C_DIV_W-1:0]   dividend;
        logic [C_RCP_W-1:0]   recip;
        logic [C_SHIFT_W-1:0] shift;
    } t_div_req;

endpackage

// ===== rtl/ultrasonic_presence_throttle_unit.sv =====
// top level: per side sample rounds, trimmed mean, change test and throttle
//
// An item is taken when start is high and busy is low. Each pulse is turned
// into centimetres by the shared reciprocal divider, a multiply and a shift,
// so an item that does not end a round keeps busy high only while it is
// converted. The item that ends a round then ranks the round in the sample
// memory, a read and a compare per sample pair over its two read ports,
// starts the mean in a state of its own, computes the mean on the same
// divider and does the change test and throttle update. The result is shown
// on o_result for one cycle with o_strobe high, in the first cycle that busy
// is low again, and cannot be held off, so the receiver must take it then.
module ultrasonic_presence_throttle_unit #(
    parameter int SAMPLES_PER_ROUND = ups_pkg::C_SAMPLES_PER_ROUND
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ups_pkg::t_item                     i_item,
    output logic                               o_strobe,
    output ups_pkg::t_result                   o_result,
    input  logic                               i_cfg_we,
    input  logic [ups_pkg::C_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ups_pkg::C_CFG_DATA_W-1:0]   i_cfg_data
);
    import ups_pkg::*;

    localparam int HALF  = SAMPLES_PER_ROUND / 2;
    localparam int IDX_W = $clog2(SAMPLES_PER_ROUND);
    localparam int AW    = IDX_W + 1;
    localparam int SUM_W = $clog2(HALF * C_CM_MAX + 1);
    localparam int CHG   = C_CHANGE_CM * HALF;
    localparam int MEAN_SHIFT = C_DIV_W + $clog2(HALF);
    localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + HALF - 1) / HALF;
    localparam logic [IDX_W-1:0]   LAST     = IDX_W'(SAMPLES_PER_ROUND - 1);
    localparam logic [C_MOD_W-1:0] LAST_MOD = C_MOD_W'(C_THROTTLE_EVERY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_RANK_RD,
        S_RANK_CMP,
        S_SUM,
        S_MEAN,
        S_UPD,
        S_THR
    } t_state;

    // sequencer state
    t_state               r_state, n_state;
    logic                 r_side, n_side;
    logic [IDX_W-1:0]     r_fill [2];
    logic [IDX_W-1:0]     n_fill [2];
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_j, n_j;
    logic [IDX_W-1:0]     r_rank, n_rank;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [C_MEAN_W-1:0]  r_mean, n_mean;
    logic                 r_changed, n_changed;
    logic                 r_strobe, n_strobe;
    t_result              r_result, n_result;

    // per side history
    logic [SUM_W-1:0]     r_prev_sum [2];
    logic [SUM_W-1:0]     n_prev_sum [2];
    logic                 r_prev_valid [2];
    logic                 n_prev_valid [2];
    logic [C_COUNT_W-1:0] r_inact [2];
    logic [C_COUNT_W-1:0] n_inact [2];
    logic [C_MOD_W-1:0]   r_mod [2];
    logic [C_MOD_W-1:0]   n_mod [2];
    logic [C_DELAY_W-1:0] r_delay [2];
    logic [C_DELAY_W-1:0] n_delay [2];

    // configuration
    logic                 r_en;
    logic [C_MS_W-1:0]    r_base;
    logic [C_MS_W-1:0]    r_max;

    // shared divider and sample memory
    t_div_req             div_req;
    logic                 div_done;
    logic [C_DIV_W-1:0]   div_quot;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [C_CM_W-1:0]    ram_wdata;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    logic [C_CM_W-1:0]    rd_a;
    logic [C_CM_W-1:0]    rd_b;

    // combinational temporaries
    logic                 less;
    logic [IDX_W-1:0]     rank_next;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W-1:0]     diff;
    logic                 chg;
    logic [C_COUNT_W-1:0] inc_cnt;
    logic [C_MOD_W-1:0]   inc_mod;
    logic [C_DELAY_W-1:0] delay_next;

    ups_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ups_ram #(
        .WIDTH (C_CM_W),
        .DEPTH (2 ** AW)
    ) u_samples (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_base <= C_BASE_DELAY_RESET;
            r_max  <= C_MAX_DELAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THROTTLE_ENABLE: r_en   <= i_cfg_data[0];
                CFG_BASE_DELAY_MS:   r_base <= i_cfg_data[C_MS_W-1:0];
                CFG_MAX_DELAY_MS:    r_max  <= i_cfg_data[C_MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_side       = r_side;
        n_fill       = r_fill;
        n_i          = r_i;
        n_j          = r_j;
        n_rank       = r_rank;
        n_sum        = r_sum;
        n_mean       = r_mean;
        n_changed    = r_changed;
        n_strobe     = 1'b0;
        n_result     = r_result;
        n_prev_sum   = r_prev_sum;
        n_prev_valid = r_prev_valid;
        n_inact      = r_inact;
        n_mod        = r_mod;
        n_delay      = r_delay;

        div_req          = '0;
        div_req.recip    = C_RCP_W'(C_CM_RECIP);
        div_req.shift    = C_SHIFT_W'(C_CM_SHIFT);
        ram_we           = 1'b0;
        ram_waddr        = {r_side, r_fill[r_side]};
        ram_wdata        = div_quot[C_CM_W-1:0];
        raddr_a          = {r_side, r_i};
        raddr_b          = {r_side, r_j};

        // ranking: sample j sorts ahead of sample i
        less      = (rd_b < rd_a) || ((rd_b == rd_a) && (r_j < r_i));
        rank_next = r_rank + IDX_W'(less);
        sum_next  = (rank_next < IDX_W'(HALF)) ? r_sum + SUM_W'(rd_a) : r_sum;

        // change test on sums
        diff = (r_sum > r_prev_sum[r_side]) ? r_sum - r_prev_sum[r_side]
                                             : r_prev_sum[r_side] - r_sum;
        chg  = !r_prev_valid[r_side] || (diff > SUM_W'(CHG));

        // saturating count, with its remainder by ten kept alongside
        if (r_inact[r_side] != C_COUNT_W'(C_COUNT_MAX)) begin
            inc_cnt = r_inact[r_side] + 1'b1;
            inc_mod = (r_mod[r_side] == LAST_MOD) ? '0 : r_mod[r_side] + 1'b1;
        end else begin
            inc_cnt = r_inact[r_side];
            inc_mod = r_mod[r_side];
        end

        // throttle step
        delay_next = r_delay[r_side];
        if (r_en && (r_inact[r_side] != '0) && (r_mod[r_side] == '0)) begin
            if (r_delay[r_side] < {1'b0, r_max}) begin
                delay_next = r_delay[r_side] + C_DELAY_W'(C_THROTTLE_STEP_MS);
            end else begin
                delay_next = {1'b0, r_max};
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_side           = i_item.side;
                    div_req.start    = 1'b1;
                    div_req.dividend = C_DIV_W'(i_item.pulse_us);
                    n_state          = S_CONV;
                end
            end
            S_CONV: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    if (r_fill[r_side] == LAST) begin
                        n_fill[r_side] = '0;
                        n_i            = '0;
                        n_j            = '0;
                        n_rank         = '0;
                        n_sum          = '0;
                        n_state        = S_RANK_RD;
                    end else begin
                        n_fill[r_side] = r_fill[r_side] + 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_RANK_RD: begin
                n_state = S_RANK_CMP;
            end
            S_RANK_CMP: begin
                if (r_j == LAST) begin
                    n_j    = '0;
                    n_rank = '0;
                    n_sum  = sum_next;
                    if (r_i == LAST) begin
                        n_state = S_SUM;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_RANK_RD;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_rank  = rank_next;
                    n_state = S_RANK_RD;
                end
            end
            S_SUM: begin
                // mean in sixteenth-cm steps from the registered sum
                div_req.start    = 1'b1;
                div_req.dividend = C_DIV_W'({r_sum, 4'b0000});
                div_req.recip    = C_RCP_W'(MEAN_RECIP);
                div_req.shift    = C_SHIFT_W'(MEAN_SHIFT);
                n_state          = S_MEAN;
            end
            S_MEAN: begin
                if (div_done) begin
                    n_mean  = div_quot[C_MEAN_W-1:0];
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_prev_sum[r_side]   = r_sum;
                n_prev_valid[r_side] = 1'b1;
                n_changed            = chg;
                if (chg) begin
                    n_inact[r_side] = '0;
                    n_mod[r_side]   = '0;
                    n_delay[r_side] = '0;
                end else if (r_side) begin
                    // right side round: both sides take the larger count
                    if (r_inact[0] > inc_cnt) begin
                        n_inact[1] = r_inact[0];
                        n_mod[1]   = r_mod[0];
                    end else begin
                        n_inact[0] = inc_cnt;
                        n_mod[0]   = inc_mod;
                        n_inact[1] = inc_cnt;
                        n_mod[1]   = inc_mod;
                    end
                end else begin
                    n_inact[0] = inc_cnt;
                    n_mod[0]   = inc_mod;
                end
                n_state = S_THR;
            end
            S_THR: begin
                n_delay[r_side]          = delay_next;
                n_strobe                 = 1'b1;
                n_result.out_side        = r_side;
                n_result.mean_cm_q4      = r_mean;
                n_result.changed         = r_changed;
                n_result.report          = r_changed && r_side;
                n_result.inactive_rounds = r_inact[r_side];
                n_result.throttle_ms     = delay_next;
                n_result.wait_ms         = C_WAIT_W'(r_base) + C_WAIT_W'(delay_next);
                n_state                  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_fill       <= '{default: '0};
            r_prev_sum   <= '{default: '0};
            r_prev_valid <= '{default: 1'b0};
            r_inact      <= '{default: '0};
            r_mod        <= '{default: '0};
            r_delay      <= '{default: '0};
        end else begin
            r_state      <= n_state;
            r_strobe     <= n_strobe;
            r_fill       <= n_fill;
            r_prev_sum   <= n_prev_sum;
            r_prev_valid <= n_prev_valid;
            r_inact      <= n_inact;
            r_mod        <= n_mod;
            r_delay      <= n_delay;
        end
        r_side    <= n_side;
        r_i       <= n_i;
        r_j       <= n_j;
        r_rank    <= n_rank;
        r_sum     <= n_sum;
        r_mean    <= n_mean;
        r_changed <= n_changed;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // checks on sequencing and results
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while sequencer still busy");

    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.changed) |->
            (o_result.inactive_rounds == '0) && (o_result.throttle_ms == '0))
        else $error("changed round left count or delay nonzero");

endmodule

// ===== rtl/ups_ram.sv =====
// generic ram, one write port and two registered read ports
module ups_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/ups_div.sv =====
// shared reciprocal divider, a registered multiply followed by a registered shift
module ups_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ups_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [ups_pkg::C_DIV_W-1:0] o_quot
);
    import ups_pkg::*;

    localparam int PROD_W = C_DIV_W + C_RCP_W;

    logic                 r_run;
    logic                 r_done;
    logic [PROD_W-1:0]    r_prod;
    logic [C_SHIFT_W-1:0] r_shift;
    logic [C_DIV_W-1:0]   r_quot;
    logic [PROD_W-1:0]    scaled;

    // quotient is the product scaled down by the shift
    always_comb begin
        scaled = r_prod >> r_shift;
    end

    // control, done in the cycle after the product, together with the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= i_req.start;
            r_done <= r_run;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod  <= PROD_W'(i_req.dividend) * PROD_W'(i_req.recip);
            r_shift <= i_req.shift;
        end
        if (r_run) begin
            r_quot <= scaled[C_DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sim/ups_tb_pkg.sv =====
// scoreboard class that predicts and checks the round results of the throttle unit
package ups_tb_pkg;
    import ups_pkg::*;

    localparam int C_HALF_ROUND   = (C_SAMPLES_PER_ROUND / 2 < 1) ? 1 : C_SAMPLES_PER_ROUND / 2;
    localparam int C_REPORT_LIMIT = 10;

    class throttle_round_checker;
        // register copies
        bit              enable;
        bit [C_MS_W-1:0] base_ms;
        bit [C_MS_W-1:0] max_ms;
        // per side round state
        int unsigned     samples[2][C_SAMPLES_PER_ROUND];
        int unsigned     fill[2];
        int unsigned     prev_sum[2];
        bit              prev_valid[2];
        int unsigned     idle_rounds[2];
        int unsigned     delay_ms[2];
        // round results still to come, oldest first
        t_result         expected_rounds[$];
        int unsigned     fail_count;
        int unsigned     result_count;

        function new();
            enable  = 1'b0;
            base_ms = C_BASE_DELAY_RESET;
            max_ms  = C_MAX_DELAY_RESET;
        endfunction

        function void note_config(logic [C_CFG_IDX_W-1:0] idx, logic [C_CFG_DATA_W-1:0] data);
            // writes to an unused index leave everything as it is
            case (idx)
                CFG_THROTTLE_ENABLE: enable  = data[0];
                CFG_BASE_DELAY_MS:   base_ms = data;
                CFG_MAX_DELAY_MS:    max_ms  = data;
                default: ;
            endcase
        endfunction

        function void note_item(t_item it);
            int unsigned s;
            int unsigned sum;
            int unsigned gap;
            int unsigned ranked[C_SAMPLES_PER_ROUND];
            int unsigned v;
            int          j;
            bit          moved;
            t_result     r;
            s = it.side;
            // store the pulse in whole centimetres
            if (fill[s] >= C_SAMPLES_PER_ROUND)
                fill[s] = 0;
            samples[s][fill[s]] = it.pulse_us / C_CM_DIVISOR;
            fill[s]++;
            if (fill[s] < C_SAMPLES_PER_ROUND)
                return;
            fill[s] = 0;

            // insertion sort of the round, then sum of the smallest half
            for (int i = 0; i < C_SAMPLES_PER_ROUND; i++) begin
                v = samples[s][i];
                j = i - 1;
                while (j >= 0 && ranked[j] > v) begin
                    ranked[j + 1] = ranked[j];
                    j--;
                end
                ranked[j + 1] = v;
            end
            sum = 0;
            for (int i = 0; i < C_HALF_ROUND; i++)
                sum += ranked[i];

            // change test on sums, first round always moves
            gap   = (sum > prev_sum[s]) ? sum - prev_sum[s] : prev_sum[s] - sum;
            moved = !prev_valid[s] || (gap > C_CHANGE_CM * C_HALF_ROUND);
            prev_sum[s]   = sum;
            prev_valid[s] = 1'b1;

            // inactivity count, right side pulls both up to the larger
            if (moved) begin
                idle_rounds[s] = 0;
                delay_ms[s]    = 0;
            end else begin
                if (idle_rounds[s] < C_COUNT_MAX)
                    idle_rounds[s]++;
                if (s == 1) begin
                    if (idle_rounds[0] > idle_rounds[1])
                        idle_rounds[1] = idle_rounds[0];
                    else
                        idle_rounds[0] = idle_rounds[1];
                end
            end

            // throttle step every tenth quiet round, clamped once at the limit
            if (enable && idle_rounds[s] != 0 && idle_rounds[s] % C_THROTTLE_EVERY == 0) begin
                if (delay_ms[s] < max_ms)
                    delay_ms[s] += C_THROTTLE_STEP_MS;
                else
                    delay_ms[s] = 32'(max_ms);
            end

            r.out_side        = it.side;
            r.mean_cm_q4      = C_MEAN_W'((sum * 16) / C_HALF_ROUND);
            r.changed         = moved;
            r.report          = moved && (s == 1);
            r.inactive_rounds = C_COUNT_W'(idle_rounds[s]);
            r.throttle_ms     = C_DELAY_W'(delay_ms[s]);
            r.wait_ms         = C_WAIT_W'(32'(base_ms) + delay_ms[s]);
            expected_rounds.insert(expected_rounds.size(), r);
        endfunction

        function string describe(t_result r);
            return $sformatf("side %0d mean_q4 %0d chg %0b rep %0b idle %0d thr %0d wait %0d",
                             r.out_side, r.mean_cm_q4, r.changed, r.report,
                             r.inactive_rounds, r.throttle_ms, r.wait_ms);
        endfunction

        function void log_failure(string msg);
            fail_count++;
            if (fail_count <= C_REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(t_result got);
            t_result want;
            result_count++;
            if (expected_rounds.size() == 0) begin
                log_failure($sformatf("round %0d not expected, got %s",
                                      result_count, describe(got)));
                return;
            end
            want = expected_rounds.pop_front();
            if (got.out_side !== want.out_side || got.mean_cm_q4 !== want.mean_cm_q4 ||
                    got.changed !== want.changed || got.report !== want.report ||
                    got.inactive_rounds !== want.inactive_rounds ||
                    got.throttle_ms !== want.throttle_ms || got.wait_ms !== want.wait_ms)
                log_failure($sformatf("round %0d expected %s, got %s",
                                      result_count, describe(want), describe(got)));
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// top level testbench of the ultrasonic presence throttle unit
module tb_top;
    import ups_pkg::*;
    import ups_tb_pkg::*;

    localparam int C_CYCLE_LIMIT  = 1000000;
    localparam int C_SETTLE_LIMIT = 4000;
    localparam int C_TAIL_CYCLES  = 250;
    localparam logic [C_CFG_IDX_W-1:0] C_CFG_UNUSED = 2'd3;

    // directed rounds at the pulse extremes
    localparam logic [C_PULSE_W-1:0] C_LEFT_EDGES[8] =
        '{16'd0, 16'd65535, 16'd57, 16'd58, 16'd65534, 16'd115, 16'd116, 16'd1};
    localparam logic [C_PULSE_W-1:0] C_RIGHT_EDGES[8] =
        '{16'd65535, 16'd65535, 16'd65535, 16'd32768, 16'd32767, 16'd65535, 16'd0, 16'd65535};

    // shape of the next round of one side
    typedef enum int {
        PLAN_STEADY,
        PLAN_JUMP,
        PLAN_BOUNDARY,
        PLAN_EXTREME
    } t_plan;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    t_item                   pulse_item    = '0;
    logic                    result_strobe;
    t_result                 round_result;
    logic                    cfg_we        = 1'b0;
    logic [C_CFG_IDX_W-1:0]  cfg_idx       = '0;
    logic [C_CFG_DATA_W-1:0] cfg_data      = '0;

    throttle_round_checker   sb;
    int unsigned             cycles        = 0;
    int unsigned             idle_pct      = 0;
    int unsigned             plan[2][C_SAMPLES_PER_ROUND];
    int unsigned             level[2];

    ultrasonic_presence_throttle_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (pulse_item),
        .o_strobe   (result_strobe),
        .o_result   (round_result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == C_CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result monitor, strobe lasts one cycle
    always @(posedge clk) begin
        if (rst_n && result_strobe)
            sb.check_result(round_result);
    end

    // pulse width for a distance, random within the centimetre
    function automatic logic [C_PULSE_W-1:0] pulse_for(input int unsigned cm);
        int unsigned room;
        room = 65535 - cm * C_CM_DIVISOR;
        return C_PULSE_W'(cm * C_CM_DIVISOR + $urandom_range(0, room < 57 ? room : 57));
    endfunction

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.note_config(idx, data);
    endtask

    // full register set plus a write to the unused index
    task automatic program_regs(input bit en, input logic [C_MS_W-1:0] base,
                                input logic [C_MS_W-1:0] limit);
        logic [C_CFG_DATA_W-1:0] en_word;
        en_word    = C_CFG_DATA_W'($urandom);
        en_word[0] = en;
        write_reg(C_CFG_UNUSED, C_CFG_DATA_W'($urandom));
        write_reg(CFG_THROTTLE_ENABLE, en_word);
        write_reg(CFG_BASE_DELAY_MS, base);
        write_reg(CFG_MAX_DELAY_MS, limit);
        cfg_we <= 1'b0;
    endtask

    // one item, with an optional gap once the block is free
    task automatic send_pulse(input logic side, input logic [C_PULSE_W-1:0] pulse);
        t_item it;
        it.side     = side;
        it.pulse_us = pulse;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        start      <= 1'b1;
        pulse_item <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    // next round of one side as centimetre values
    task automatic build_round(input int s, input t_plan kind, input int unsigned margin);
        int unsigned target;
        int unsigned lo;
        int unsigned hi;
        int unsigned tmp;
        int          j;
        case (kind)
            PLAN_JUMP:    level[s] = $urandom_range(0, C_CM_MAX);
            PLAN_EXTREME: level[s] = $urandom_range(0, 1) ? C_CM_MAX : 0;
            default: ;
        endcase
        if (kind == PLAN_BOUNDARY && sb.prev_valid[s]) begin
            // smallest half sums to exactly the previous sum plus or minus the margin
            if (sb.prev_sum[s] + margin <= C_HALF_ROUND * C_CM_MAX &&
                    (sb.prev_sum[s] < margin || $urandom_range(0, 1)))
                target = sb.prev_sum[s] + margin;
            else
                target = sb.prev_sum[s] - margin;
            lo = target / C_HALF_ROUND;
            hi = lo + target % C_HALF_ROUND;
            for (int i = 0; i < C_SAMPLES_PER_ROUND; i++) begin
                if (i < C_HALF_ROUND - 1)
                    plan[s][i] = lo;
                else if (i == C_HALF_ROUND - 1)
                    plan[s][i] = hi;
                else begin
                    tmp        = hi + $urandom_range(0, 3);
                    plan[s][i] = (tmp > C_CM_MAX) ? C_CM_MAX : tmp;
                end
            end
            level[s] = lo;
        end else begin
            // small jitter around the side's level
            for (int i = 0; i < C_SAMPLES_PER_ROUND; i++) begin
                tmp        = level[s] + ((kind == PLAN_EXTREME) ? 0 : $urandom_range(0, 3));
                plan[s][i] = (tmp > C_CM_MAX) ? C_CM_MAX : tmp;
            end
        end
        // arrival order is random
        for (int i = 0; i < C_SAMPLES_PER_ROUND; i++) begin
            j          = $urandom_range(0, C_SAMPLES_PER_ROUND - 1);
            tmp        = plan[s][i];
            plan[s][i] = plan[s][j];
            plan[s][j] = tmp;
        end
    endtask

    // random rounds on both sides, some disturbed, some noise pulses
    task automatic run_phase(input int items, input int disturb_pct, input int noise_pct);
        int                   s;
        int unsigned          pos;
        t_plan                kind;
        logic [C_PULSE_W-1:0] pulse;
        for (int n = 0; n < items; n++) begin
            s   = $urandom_range(0, 1);
            pos = sb.fill[s];
            if (pos == 0) begin
                kind = PLAN_STEADY;
                if ($urandom_range(0, 99) < disturb_pct)
                    kind = t_plan'($urandom_range(PLAN_JUMP, PLAN_EXTREME));
                build_round(s, kind, C_CHANGE_CM * C_HALF_ROUND + $urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < noise_pct)
                pulse = C_PULSE_W'($urandom_range(0, 65535));
            else
                pulse = pulse_for(plan[s][pos]);
            send_pulse(s[0], pulse);
        end
    endtask

    // wait for outstanding rounds and a quiet block
    task automatic settle();
        int unsigned waited;
        start  <= 1'b0;
        waited = 0;
        while ((sb.expected_rounds.size() != 0 || busy) && waited < C_SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (C_TAIL_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pulse extremes, first rounds, change threshold met exactly
        program_regs(1'b0, C_BASE_DELAY_RESET, C_MAX_DELAY_RESET);
        for (int i = 0; i < 8; i++)
            send_pulse(1'b0, C_LEFT_EDGES[i]);
        for (int i = 0; i < 8; i++)
            send_pulse(1'b1, C_RIGHT_EDGES[i]);
        build_round(0, PLAN_BOUNDARY, C_CHANGE_CM * C_HALF_ROUND);
        for (int i = 0; i < C_SAMPLES_PER_ROUND; i++)
            send_pulse(1'b0, pulse_for(plan[0][i]));
        settle();

        // busy changes, throttle on, zero base and widest limit
        idle_pct = 30;
        program_regs(1'b1, '0, '1);
        run_phase(350, 25, 3);
        settle();

        // quiet rounds so the delay grows, largest base
        idle_pct = 45;
        program_regs(1'b1, '1, C_MS_W'($urandom_range(300, 2000)));
        run_phase(450, 2, 0);
        settle();

        // limit dropped under the current delay
        idle_pct = 0;
        program_regs(1'b1, C_MS_W'($urandom), '0);
        run_phase(250, 2, 0);
        settle();

        // throttle off
        program_regs(1'b0, C_MS_W'($urandom), C_MS_W'(C_THROTTLE_STEP_MS));
        run_phase(350, 15, 3);
        settle();

        if (sb.expected_rounds.size() != 0)
            sb.log_failure($sformatf("%0d rounds never reported", sb.expected_rounds.size()));
        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
